// ===== design/frf_pkg.sv =====
// Shared types and constants for the framed ring FIFO.
// No dependencies; imported by every module of the block.
package frf_pkg;

   localparam int BUFFER_BYTES = 4096;
   localparam int PTR_W = $clog2(BUFFER_BYTES);
   localparam int CNT_W = PTR_W + 1;
   localparam logic [CNT_W-1:0] HEADER_BYTES = CNT_W'(12);
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ACT_BEGIN = 3'd0,
      ACT_BYTE  = 3'd1,
      ACT_READ  = 3'd2,
      ACT_FETCH = 3'd3,
      ACT_CLEAR = 3'd4,
      ACT_NOP5  = 3'd5,
      ACT_NOP6  = 3'd6,
      ACT_NOP7  = 3'd7
   } action_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [11:0] frame_len;
      logic [31:0] frame_type;
      logic [31:0] frame_stamp;
      logic [7:0]  data_byte;
      logic [11:0] max_len;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        frame_found;
      logic [11:0] frame_size;
      logic [31:0] out_type;
      logic [31:0] out_stamp;
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last_byte;
      logic [12:0] fill_level;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE_HDR,
      ST_READ_HDR,
      ST_READ_WAIT,
      ST_FETCH_WAIT,
      ST_DONE
   } state_type;

endpackage

// ===== design/framed_ring_fifo.sv =====
// Top level of the framed ring FIFO: request queue feeding the frame engine.
// Payload byte, fetch, clear, no-op, refused begin and empty read need no header transfer;
// begin frame makes 12 header byte writes, read frame makes 12 header byte reads.
// One request at a time in the engine, started once the last response is popped; 2 queue.
// Synchronous active-high reset empties the queue, pointers and fill count; the
// ring memory holds no reset value.
module framed_ring_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  frf_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output frf_pkg::rsp_type rsp_data
);
   import frf_pkg::*;

   logic    cmd_valid, cmd_take;
   req_type cmd_data;

   frf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data)
   );

   frf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/frf_front.sv =====
// Front part: request queue that decouples the requester from the engine.
// Depends on frf_pkg.
module frf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  frf_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output frf_pkg::req_type cmd_data
);
   import frf_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   req_type            slot_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W:0]     count_ff, count_in;
   logic               push_ok, take_ok;

   assign req_full  = (count_ff == (IDX_W+1)'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = slot_ff[head_ff];
   assign push_ok   = req_push && !req_full;
   assign take_ok   = cmd_take && cmd_valid;

   always_comb begin
      head_in  = take_ok ? head_ff + 1'b1 : head_ff;
      tail_in  = push_ok ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + (IDX_W+1)'(push_ok) - (IDX_W+1)'(take_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[tail_ff] <= req_data;
      end
   end

endmodule

// ===== design/frf_back.sv =====
// Back part: frame engine with the byte ring memory and the result register.
// Depends on frf_pkg.
module frf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  frf_pkg::req_type cmd_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output frf_pkg::rsp_type rsp_data
);
   import frf_pkg::*;

   logic [7:0] ring_mem [BUFFER_BYTES];

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] used_ff, used_in, wleft_ff, wleft_in, wtotal_ff, wtotal_in;
   logic [CNT_W-1:0] dleft_ff, dleft_in, sleft_ff, sleft_in;
   logic             wopen_ff, wopen_in;
   logic [3:0]       step_ff, step_in;
   logic [95:0]      hdr_ff, hdr_in;
   req_type          cmd_ff, cmd_in;
   rsp_type          rsp_ff, rsp_in;
   logic             full_ff, full_in;
   logic             mem_we;
   logic [PTR_W-1:0] mem_wa, mem_ra;
   logic [7:0]       mem_wd, mem_rd_ff;
   logic [CNT_W-1:0] size_c, dlv_c, skp_c, disc_c, used_after, free_c;
   logic [CNT_W-1:0] need_c;

   assign rsp_empty = !full_ff;
   assign rsp_data  = rsp_ff;
   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid && !full_ff;
   assign free_c    = CNT_W'(BUFFER_BYTES) - used_ff;
   assign need_c    = HEADER_BYTES + CNT_W'(cmd_ff.frame_len);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= ring_mem[mem_ra];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               state_in = ST_DONE;
               unique case (action_type'(cmd_data.action))
                  ACT_BEGIN: state_in = ST_WRITE_HDR;
                  ACT_READ:  state_in = ST_READ_HDR;
                  ACT_FETCH: state_in = ST_FETCH_WAIT;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_WRITE_HDR: begin
            if (wopen_ff || (need_c > free_c) || step_ff == 4'd11) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_HDR: begin
            if (used_after < HEADER_BYTES) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ_WAIT;
            end
         end
         ST_READ_WAIT: begin
            if (step_ff == 4'd12) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH_WAIT: state_in = ST_IDLE;
         ST_DONE:       state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   assign disc_c     = (dleft_ff + sleft_ff > used_ff) ? used_ff : dleft_ff + sleft_ff;
   assign used_after = used_ff - disc_c;
   assign size_c = ({1'b0, hdr_ff[11:0]} > used_ff) ? used_ff : {1'b0, hdr_ff[11:0]};
   assign dlv_c  = (CNT_W'(cmd_ff.max_len) < size_c) ? CNT_W'(cmd_ff.max_len) : size_c;
   assign skp_c  = size_c - dlv_c;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      used_in   = used_ff;
      wleft_in  = wleft_ff;
      wtotal_in = wtotal_ff;
      dleft_in  = dleft_ff;
      sleft_in  = sleft_ff;
      wopen_in  = wopen_ff;
      step_in   = step_ff;
      hdr_in    = hdr_ff;
      cmd_in    = cmd_ff;
      rsp_in    = rsp_ff;
      full_in   = full_ff && !rsp_pop;
      mem_we    = 1'b0;
      mem_wa    = wr_ptr_ff;
      mem_wd    = 8'd0;
      mem_ra    = rd_ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               cmd_in  = cmd_data;
               step_in = '0;
               rsp_in  = '0;
               hdr_in  = {cmd_data.frame_stamp, cmd_data.frame_type,
                          20'd0, cmd_data.frame_len};
               unique case (action_type'(cmd_data.action))
                  ACT_BYTE: begin
                     if (wopen_ff) begin
                        mem_we         = 1'b1;
                        mem_wd         = cmd_data.data_byte;
                        wr_ptr_in      = wr_ptr_ff + 1'b1;
                        rsp_in.accepted = 1'b1;
                        if (wleft_ff <= CNT_W'(1)) begin
                           used_in   = used_ff + wtotal_ff + 1'b1;
                           wopen_in  = 1'b0;
                           wtotal_in = '0;
                           wleft_in  = '0;
                        end else begin
                           wleft_in  = wleft_ff - 1'b1;
                           wtotal_in = wtotal_ff + 1'b1;
                        end
                     end
                  end
                  ACT_CLEAR: begin
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     used_in   = '0;
                     wopen_in  = 1'b0;
                     wleft_in  = '0;
                     wtotal_in = '0;
                     dleft_in  = '0;
                     sleft_in  = '0;
                  end
                  ACT_READ: begin
                     rd_ptr_in = rd_ptr_ff + disc_c[PTR_W-1:0];
                     mem_ra    = rd_ptr_ff + disc_c[PTR_W-1:0];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRITE_HDR: begin
            if (!wopen_ff && !(need_c > free_c)) begin
               mem_we    = 1'b1;
               mem_wd    = hdr_ff[7:0];
               hdr_in    = hdr_ff >> 8;
               wr_ptr_in = wr_ptr_ff + 1'b1;
               step_in   = step_ff + 1'b1;
               if (step_ff == 4'd11) begin
                  rsp_in.accepted = 1'b1;
                  if (cmd_ff.frame_len == 12'd0) begin
                     used_in = used_ff + HEADER_BYTES;
                  end else begin
                     wopen_in  = 1'b1;
                     wleft_in  = CNT_W'(cmd_ff.frame_len);
                     wtotal_in = HEADER_BYTES;
                  end
               end
            end
            if (wopen_ff || (need_c > free_c) || step_ff == 4'd11) begin
               full_in = 1'b1;
               rsp_in.fill_level = 13'(used_in);
            end
         end
         ST_READ_HDR: begin
            used_in  = used_after;
            dleft_in = '0;
            sleft_in = '0;
            if (used_after < HEADER_BYTES) begin
               full_in = 1'b1;
               rsp_in.fill_level = 13'(used_after);
            end else begin
               hdr_in    = {mem_rd_ff, hdr_ff[95:8]};
               rd_ptr_in = rd_ptr_ff + 1'b1;
               mem_ra    = rd_ptr_ff + 1'b1;
               step_in   = 4'd1;
            end
         end
         ST_READ_WAIT: begin
            hdr_in  = {mem_rd_ff, hdr_ff[95:8]};
            step_in = step_ff + 1'b1;
            if (step_ff != 4'd12) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
               mem_ra    = rd_ptr_ff + 1'b1;
            end
            if (step_ff == 4'd11) begin
               used_in   = used_ff - HEADER_BYTES;
            end
            if (step_ff == 4'd12) begin
               rd_ptr_in = rd_ptr_ff;
               full_in   = 1'b1;
               dleft_in  = dlv_c;
               sleft_in  = skp_c;
               rsp_in.frame_found = 1'b1;
               rsp_in.frame_size  = size_c[11:0];
               rsp_in.out_type    = hdr_ff[63:32];
               rsp_in.out_stamp   = hdr_ff[95:64];
               if (dlv_c == '0) begin
                  rd_ptr_in = rd_ptr_ff + skp_c[PTR_W-1:0];
                  used_in   = used_ff - skp_c;
                  sleft_in  = '0;
               end
               rsp_in.fill_level = 13'(used_in);
            end
         end
         ST_FETCH_WAIT: begin
            full_in = 1'b1;
            if (dleft_ff != '0 && used_ff != '0) begin
               rsp_in.out_byte   = mem_rd_ff;
               rsp_in.byte_valid = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
               used_in   = used_ff - 1'b1;
               dleft_in  = dleft_ff - 1'b1;
               if (dleft_ff == CNT_W'(1)) begin
                  rsp_in.last_byte = 1'b1;
                  rd_ptr_in = rd_ptr_ff + 1'b1 + sleft_ff[PTR_W-1:0];
                  used_in   = (sleft_ff > used_ff - 1'b1) ? '0
                              : used_ff - 1'b1 - sleft_ff;
                  sleft_in  = '0;
               end
            end
            rsp_in.fill_level = 13'(used_in);
         end
         ST_DONE: begin
            full_in = 1'b1;
            rsp_in.fill_level = 13'(used_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         used_ff   <= '0;
         wleft_ff  <= '0;
         wtotal_ff <= '0;
         dleft_ff  <= '0;
         sleft_ff  <= '0;
         wopen_ff  <= 1'b0;
         full_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         used_ff   <= used_in;
         wleft_ff  <= wleft_in;
         wtotal_ff <= wtotal_in;
         dleft_ff  <= dleft_in;
         sleft_ff  <= sleft_in;
         wopen_ff  <= wopen_in;
         full_ff   <= full_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== verif/tb_framed_ring_fifo.sv =====
// Testbench for the framed ring FIFO: drives requests through the push/full queue,
// predicts every response with a behavioral copy of the frame buffer and compares.
// Depends on frf_pkg and framed_ring_fifo from the design folder.
module tb_framed_ring_fifo;
   import frf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   framed_ring_fifo u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   // Behavioral copy of the frame buffer.
   logic [7:0] ring_mem [BUFFER_BYTES];
   int unsigned rd_ptr, wr_ptr, committed, open_left, open_total, give_left, drop_left;
   logic       open_frame;

   rsp_type expected_rsps[$];
   int unsigned error_count, rsp_count, found_count, fetched_count, sent_count;
   int unsigned idle_cycles;
   bit         stim_done;

   function automatic void buffer_reset();
      rd_ptr = 0; wr_ptr = 0; committed = 0; open_frame = 0;
      open_left = 0; open_total = 0; give_left = 0; drop_left = 0;
   endfunction

   function automatic void put_byte(logic [7:0] b);
      ring_mem[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % BUFFER_BYTES;
   endfunction

   function automatic logic [7:0] take_byte();
      logic [7:0] b;
      b = ring_mem[rd_ptr];
      rd_ptr = (rd_ptr + 1) % BUFFER_BYTES;
      if (committed > 0) committed--;
      return b;
   endfunction

   function automatic logic [31:0] take_word();
      logic [31:0] w;
      for (int i = 0; i < 4; i++) w[8*i +: 8] = take_byte();
      return w;
   endfunction

   function automatic void release_bytes(int unsigned n);
      if (n > committed) n = committed;
      rd_ptr = (rd_ptr + n) % BUFFER_BYTES;
      committed -= n;
   endfunction

   function automatic rsp_type frame_step(req_type rq);
      rsp_type     r;
      int unsigned size;
      r = '0;
      case (action_type'(rq.action))
         ACT_BEGIN: begin
            if (!open_frame && 12 + rq.frame_len <= BUFFER_BYTES - committed) begin
               for (int i = 0; i < 4; i++) put_byte(8'({20'd0, rq.frame_len} >> (8*i)));
               for (int i = 0; i < 4; i++) put_byte(rq.frame_type[8*i +: 8]);
               for (int i = 0; i < 4; i++) put_byte(rq.frame_stamp[8*i +: 8]);
               r.accepted = 1;
               if (rq.frame_len == 0) committed += 12;
               else begin
                  open_frame = 1; open_left = rq.frame_len; open_total = 12;
               end
            end
         end
         ACT_BYTE: begin
            if (open_frame) begin
               put_byte(rq.data_byte);
               open_total++;
               if (open_left > 0) open_left--;
               r.accepted = 1;
               if (open_left == 0) begin
                  committed += open_total; open_frame = 0; open_total = 0;
               end
            end
         end
         ACT_READ: begin
            release_bytes(give_left + drop_left);
            give_left = 0; drop_left = 0;
            if (committed >= 12) begin
               size = take_word();
               r.out_type = take_word();
               r.out_stamp = take_word();
               if (size > committed) size = committed;
               give_left = (rq.max_len < size) ? rq.max_len : size;
               drop_left = size - give_left;
               if (give_left == 0) begin
                  release_bytes(drop_left); drop_left = 0;
               end
               r.frame_found = 1;
               r.frame_size = 12'(size);
            end
         end
         ACT_FETCH: begin
            if (give_left > 0 && committed > 0) begin
               r.out_byte = take_byte();
               r.byte_valid = 1;
               give_left--;
               if (give_left == 0) begin
                  r.last_byte = 1;
                  release_bytes(drop_left); drop_left = 0;
               end
            end
         end
         ACT_CLEAR: buffer_reset();
         default: ;
      endcase
      r.fill_level = 13'(committed);
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned gap_len();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Sends one request; a check row carries a typed expectation on top of the predictor.
   task automatic send_request(req_type rq);
      int unsigned gap;
      gap = gap_len();
      if (gap != 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_data <= rq;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_rsps.push_back(frame_step(rq));
      sent_count++;
   endtask

   task automatic drain_wait();
      req_push <= 0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_req(action_type a, int unsigned len, logic [31:0] t,
                                        logic [31:0] s, logic [7:0] d, int unsigned ml);
      req_type rq;
      rq.action = a; rq.frame_len = 12'(len); rq.frame_type = t;
      rq.frame_stamp = s; rq.data_byte = d; rq.max_len = 12'(ml);
      return rq;
   endfunction

   typedef struct {
      req_type    rq;
      bit         has_fixed;
      rsp_type    fixed;
   } stim_row_type;

   stim_row_type stim_table[$];

   function automatic void add_row(req_type rq, bit has_fixed, rsp_type fixed);
      stim_row_type row;
      row.rq = rq; row.has_fixed = has_fixed; row.fixed = fixed;
      stim_table.push_back(row);
   endfunction

   function automatic rsp_type fill_only(int unsigned lvl);
      rsp_type r;
      r = '0; r.fill_level = 13'(lvl);
      return r;
   endfunction

   task automatic send_frame(int unsigned len);
      send_request(make_req(ACT_BEGIN, len, $urandom, $urandom, 0, 0));
      for (int i = 0; i < len; i++)
         send_request(make_req(ACT_BYTE, 0, 0, 0, 8'($urandom), 0));
   endtask

   task automatic read_frame(int unsigned ml, int unsigned fetches);
      send_request(make_req(ACT_READ, 0, 0, 0, 0, ml));
      repeat (fetches) send_request(make_req(ACT_FETCH, 0, 0, 0, 0, 0));
   endtask

   task automatic random_noise();
      req_type    rq;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      rq = raw[$bits(req_type)-1:0];
      send_request(rq);
   endtask

   initial begin
      rsp_type r0;
      r0 = '0;
      reset = 1; req_push = 0; req_data = '0; rsp_pop = 0; sent_count = 0;
      buffer_reset();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed rows.
      r0.accepted = 0;
      add_row(make_req(ACT_READ, 0, 0, 0, 0, 4084), 1, fill_only(0));
      add_row(make_req(ACT_FETCH, 0, 0, 0, 0, 0), 1, fill_only(0));
      add_row(make_req(ACT_BYTE, 0, 0, 0, 8'hFF, 0), 1, fill_only(0));
      add_row(make_req(ACT_NOP5, 4084, '1, '1, 8'hFF, 4084), 1, fill_only(0));
      add_row(make_req(ACT_BEGIN, 0, '1, '1, 0, 0), 0, r0);
      add_row(make_req(ACT_BEGIN, 3, 32'h0, 32'h0, 0, 0), 0, r0);
      add_row(make_req(ACT_BEGIN, 5, 1, 1, 0, 0), 0, r0);
      add_row(make_req(ACT_BYTE, 0, 0, 0, 8'h00, 0), 0, r0);
      add_row(make_req(ACT_BYTE, 0, 0, 0, 8'hFF, 0), 0, r0);
      add_row(make_req(ACT_BYTE, 0, 0, 0, 8'hA5, 0), 0, r0);
      add_row(make_req(ACT_READ, 0, 0, 0, 0, 0), 0, r0);
      add_row(make_req(ACT_READ, 0, 0, 0, 0, 2), 0, r0);
      add_row(make_req(ACT_FETCH, 0, 0, 0, 0, 0), 0, r0);
      add_row(make_req(ACT_FETCH, 0, 0, 0, 0, 0), 0, r0);
      add_row(make_req(ACT_FETCH, 0, 0, 0, 0, 0), 0, r0);
      add_row(make_req(ACT_NOP6, 0, 0, 0, 0, 0), 0, r0);
      add_row(make_req(ACT_BEGIN, 4084, 32'h1234, 32'h5678, 0, 0), 0, r0);
      add_row(make_req(ACT_BEGIN, 4085 - 1, 0, 0, 0, 0), 0, r0);
      add_row(make_req(ACT_NOP7, 0, 0, 0, 0, 0), 0, r0);
      add_row(make_req(ACT_CLEAR, 0, 0, 0, 0, 0), 1, fill_only(0));
      add_row(make_req(ACT_BYTE, 0, 0, 0, 8'h5A, 0), 1, fill_only(0));

      foreach (stim_table[i]) begin
         send_request(stim_table[i].rq);
         if (stim_table[i].has_fixed && expected_rsps[$] !== stim_table[i].fixed) begin
            $error("directed row %0d: predictor disagrees with typed value", i);
            error_count++;
         end
      end

      // Fill to the brim with empty frames and one payload frame, then read it all back
      // so that both pointers wrap.
      repeat (330) send_request(make_req(ACT_BEGIN, 0, $urandom, $urandom, 0, 0));
      send_frame(124);
      send_request(make_req(ACT_BEGIN, 0, 0, 0, 0, 0));
      send_request(make_req(ACT_BYTE, 0, 0, 0, 8'h3C, 0));
      repeat (330) read_frame(4084, 0);
      read_frame(2, 3);
      send_request(make_req(ACT_CLEAR, 0, 0, 0, 0, 0));
      drain_wait();

      // Random part: mostly well-formed frame traffic, some noise.
      while (sent_count < 1050) begin
         int unsigned p;
         p = $urandom_range(99);
         if (p < 45) send_frame($urandom_range(99) < 85 ? $urandom_range(12) :
                                $urandom_range(300));
         else if (p < 85) read_frame($urandom_range(99) < 80 ? $urandom_range(12) :
                                     $urandom_range(4084), $urandom_range(14));
         else if (p < 97) random_noise();
         else send_request(make_req(ACT_CLEAR, 0, 0, 0, 0, 0));
         if ($urandom_range(199) == 0) drain_wait();
      end
      drain_wait();
      stim_done = 1;
   end

   // Response side: random pop stalls and checking.
   initial begin
      rsp_type exp_rsp;
      int unsigned stall;
      rsp_count = 0; error_count = 0; stim_done = 0;
      @(negedge reset);
      forever begin
         stall = gap_len();
         if (stall != 0) begin
            rsp_pop <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         if (expected_rsps.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.accepted !== exp_rsp.accepted) begin
               $error("accepted exp %0h got %0h", exp_rsp.accepted, rsp_data.accepted);
               error_count++;
            end
            if (rsp_data.frame_found !== exp_rsp.frame_found) begin
               $error("frame_found exp %0h got %0h", exp_rsp.frame_found,
                      rsp_data.frame_found);
               error_count++;
            end
            if (rsp_data.frame_size !== exp_rsp.frame_size) begin
               $error("frame_size exp %0h got %0h", exp_rsp.frame_size, rsp_data.frame_size);
               error_count++;
            end
            if (rsp_data.out_type !== exp_rsp.out_type) begin
               $error("out_type exp %0h got %0h", exp_rsp.out_type, rsp_data.out_type);
               error_count++;
            end
            if (rsp_data.out_stamp !== exp_rsp.out_stamp) begin
               $error("out_stamp exp %0h got %0h", exp_rsp.out_stamp, rsp_data.out_stamp);
               error_count++;
            end
            if (rsp_data.out_byte !== exp_rsp.out_byte) begin
               $error("out_byte exp %0h got %0h", exp_rsp.out_byte, rsp_data.out_byte);
               error_count++;
            end
            if (rsp_data.byte_valid !== exp_rsp.byte_valid) begin
               $error("byte_valid exp %0h got %0h", exp_rsp.byte_valid, rsp_data.byte_valid);
               error_count++;
            end
            if (rsp_data.last_byte !== exp_rsp.last_byte) begin
               $error("last_byte exp %0h got %0h", exp_rsp.last_byte, rsp_data.last_byte);
               error_count++;
            end
            if (rsp_data.fill_level !== exp_rsp.fill_level) begin
               $error("fill_level exp %0h got %0h", exp_rsp.fill_level, rsp_data.fill_level);
               error_count++;
            end
            if (exp_rsp.frame_found) found_count++;
            if (exp_rsp.byte_valid) fetched_count++;
         end
         rsp_count++;
      end
   end

   // Watchdog, end of run and final verdict.
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
         if (stim_done) begin
            repeat (40) @(posedge clock);
            if (expected_rsps.size() != 0 || !rsp_empty) error_count++;
            $display("Sent %0d requests and checked %0d responses, including a full buffer",
                     sent_count, rsp_count);
            $display("and pointer wrap: %0d frame headers popped, %0d bytes fetched.",
                     found_count, fetched_count);
            if (error_count == 0) $display("SCOREBOARD CLEAN");
            else $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule
